FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the core.
// No dependencies; each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with a fixed report text.
`define EFT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("event flag table assertion failed");

// Concurrent assertion with a caller-supplied report text.
`define EFT_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

FILE: rtl/core/eft_pkg.sv
// Package of the event flag table: item types, command and operation codes, sizes.
// No dependencies; imported by every module of the core.
package eft_pkg;

	localparam int SOURCES_DEFAULT = 128;
	localparam int QUEUE_DEPTH     = 2;
	localparam int MASK_W          = 16;
	localparam int MAX_SIGNAL      = 15;

	// Command codes as they arrive on the request.
	localparam logic [2:0] CMD_CREATE   = 3'd0;
	localparam logic [2:0] CMD_REGISTER = 3'd1;
	localparam logic [2:0] CMD_LISTEN   = 3'd2;
	localparam logic [2:0] CMD_TRIGGER  = 3'd3;
	localparam logic [2:0] CMD_CANCEL   = 3'd4;

	// Operation codes handed from the front to the back.
	localparam logic [2:0] OP_FAIL     = 3'd0;
	localparam logic [2:0] OP_CREATE   = 3'd1;
	localparam logic [2:0] OP_REGISTER = 3'd2;
	localparam logic [2:0] OP_LISTEN   = 3'd3;
	localparam logic [2:0] OP_TRIGGER  = 3'd4;
	localparam logic [2:0] OP_CANCEL   = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] source_number;
		logic [7:0] listener_number;
		logic [4:0] signal_number;
	} request_t;

	typedef struct packed {
		logic       success;
		logic [7:0] new_source;
	} response_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] source;
		logic [3:0] signal;
		logic [7:0] new_source;
	} op_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

FILE: rtl/core/eft_queue.sv
// Small first-in first-out queue of register slots, generic in depth and item type.
// Depends on eft_pkg for the default depth and the status struct.
module eft_queue
	import eft_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH,
	parameter type item_t = logic
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_t         wr_item,
	input  logic          pop,
	output item_t         rd_item,
	output queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// Status and handshake qualification.
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rd_item      = slots_q[rd_ptr_q];

	// Item storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/eft_front.sv
// Front of the event flag table: accepts requests, checks ranges and existence,
// allocates source numbers and hands one operation per item to the back. Uses eft_pkg.
module eft_front
	import eft_pkg::*;
#(
	parameter int TABLE_SOURCES = SOURCES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  request_t      request,
	input  queue_status_t op_status,
	output logic          op_push,
	output op_item_t      op
);

	localparam logic [7:0] SOURCES_8 = 8'(TABLE_SOURCES);

	logic [7:0] alloc_count_q;
	logic       src_ok;
	logic       lis_ok;
	logic       sig_ok;

	assign full    = op_status.full;
	assign op_push = push && !op_status.full;

	// A source exists when its number is below both the table size and the count.
	assign src_ok = (request.source_number < SOURCES_8) &&
		(request.source_number < alloc_count_q);
	assign lis_ok = (request.listener_number < SOURCES_8) &&
		(request.listener_number < alloc_count_q) &&
		!((request.listener_number != 8'd0) && (request.source_number == 8'd0));
	assign sig_ok = (request.signal_number <= 5'(MAX_SIGNAL));

	// Classify the command into an operation for the back.
	always_comb begin
		op.op         = OP_FAIL;
		op.source     = request.source_number;
		op.signal     = request.signal_number[3:0];
		op.new_source = 8'd0;
		unique case (request.command)
			CMD_CREATE: begin
				if (alloc_count_q < SOURCES_8) begin
					op.op         = OP_CREATE;
					op.source     = alloc_count_q;
					op.new_source = alloc_count_q;
				end
			end
			CMD_REGISTER: begin
				if (sig_ok && src_ok) begin
					op.op = OP_REGISTER;
				end
			end
			CMD_LISTEN: begin
				if (sig_ok && src_ok && lis_ok) begin
					op.op = OP_LISTEN;
				end
			end
			CMD_TRIGGER: begin
				if (sig_ok && src_ok) begin
					op.op = OP_TRIGGER;
				end
			end
			CMD_CANCEL: begin
				if (sig_ok && src_ok) begin
					op.op = OP_CANCEL;
				end
			end
			default: begin
				op.op = OP_FAIL;
			end
		endcase
	end

	// Allocation count; source 0 exists from reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_count_q <= 8'd1;
		end else if (op_push && (op.op == OP_CREATE)) begin
			alloc_count_q <= alloc_count_q + 8'd1;
		end
	end

endmodule

FILE: rtl/core/eft_back.sv
// Back of the event flag table: read-modify-write of one source entry per operation
// in the entry memory, producing one response each. Uses eft_pkg.
module eft_back
	import eft_pkg::*;
#(
	parameter int TABLE_SOURCES = SOURCES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t op_status,
	input  op_item_t      op,
	output logic          op_pop,
	input  queue_status_t res_status,
	output logic          res_push,
	output response_t     res
);

	localparam int IDX_W = $clog2(TABLE_SOURCES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                  state_q;
	op_item_t              op_q;
	logic                  zero_written_q;
	logic [2*MASK_W-1:0]   rd_data_q;
	logic [2*MASK_W-1:0]   entry_mem_q [TABLE_SOURCES];
	logic [IDX_W-1:0]      rd_idx;
	logic [IDX_W-1:0]      wr_idx;
	logic [2*MASK_W-1:0]   entry;
	logic [MASK_W-1:0]     reg_mask;
	logic [MASK_W-1:0]     pend_mask;
	logic [MASK_W-1:0]     bit_mask;
	logic                  reg_bit;
	logic                  pend_bit;
	logic                  ok;
	logic [2*MASK_W-1:0]   wr_data;
	logic                  wr_en;

	// Start an operation when one waits and the response queue has room.
	assign op_pop   = (state_q == ST_IDLE) && !op_status.empty && !res_status.full;
	assign rd_idx   = op.source[IDX_W-1:0];
	assign wr_idx   = op_q.source[IDX_W-1:0];
	assign res_push = (state_q == ST_EXEC);
	assign wr_en    = (state_q == ST_EXEC) && ok;

	// Entry memory: registered read, single write port, no reset.
	always_ff @(posedge clk) begin
		if (op_pop) begin
			rd_data_q <= entry_mem_q[rd_idx];
		end
		if (wr_en) begin
			entry_mem_q[wr_idx] <= wr_data;
		end
	end

	// Source 0 reads as cleared until the first write to it.
	assign entry     = ((wr_idx == '0) && !zero_written_q) ? '0 : rd_data_q;
	assign reg_mask  = entry[2*MASK_W-1:MASK_W];
	assign pend_mask = entry[MASK_W-1:0];
	assign bit_mask  = MASK_W'(1) << op_q.signal;
	assign reg_bit   = |(reg_mask & bit_mask);
	assign pend_bit  = |(pend_mask & bit_mask);

	// Apply the operation to the entry.
	always_comb begin
		ok      = 1'b0;
		wr_data = entry;
		unique case (op_q.op) inside
			OP_CREATE: begin
				ok      = 1'b1;
				wr_data = '0;
			end
			OP_REGISTER: begin
				ok      = !reg_bit;
				wr_data = {reg_mask | bit_mask, pend_mask};
			end
			OP_LISTEN, OP_CANCEL: begin
				ok      = reg_bit && pend_bit;
				wr_data = {reg_mask, pend_mask & ~bit_mask};
			end
			OP_TRIGGER: begin
				ok      = reg_bit && !pend_bit;
				wr_data = {reg_mask, pend_mask | bit_mask};
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign res.success    = ok;
	assign res.new_source = op_q.new_source;

	// Operation register needs no reset.
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op;
		end
	end

	// Sequencer and source 0 write flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			zero_written_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (op_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (wr_en && (wr_idx == '0)) begin
						zero_written_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/event_flag_table_core.sv
// Event flag table core. An accepted request is registered in the op queue, the back
// and the response queue in turn. The back handles one item at a time in two steps
// (registered read of the entry memory, then modify and write on its single port).
// Reset sets the allocation count to one and clears the queues; source 0 reads as
// zero until first written, so no clearing pass is needed.
// Depends on eft_pkg, eft_front, eft_queue and eft_back.
module event_flag_table_core
	import eft_pkg::*;
#(
	parameter int TABLE_SOURCES = SOURCES_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  request_t  request,
	output logic      empty,
	input  logic      pop,
	output response_t response
);

	queue_status_t op_status;
	queue_status_t res_status;
	op_item_t      front_op;
	op_item_t      back_op;
	logic          op_push;
	logic          op_pop;
	logic          res_push;
	response_t     back_res;

	assign empty = res_status.empty;

	// Request checking and allocation.
	eft_front #(
		.TABLE_SOURCES(TABLE_SOURCES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.op_status(op_status),
		.op_push  (op_push),
		.op       (front_op)
	);

	// Operations waiting for the back.
	eft_queue #(
		.DEPTH (QUEUE_DEPTH),
		.item_t(op_item_t)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wr_item(front_op),
		.pop    (op_pop),
		.rd_item(back_op),
		.status (op_status)
	);

	// Entry memory and read-modify-write.
	eft_back #(
		.TABLE_SOURCES(TABLE_SOURCES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_status (op_status),
		.op        (back_op),
		.op_pop    (op_pop),
		.res_status(res_status),
		.res_push  (res_push),
		.res       (back_res)
	);

	// Responses waiting to be taken.
	eft_queue #(
		.DEPTH (QUEUE_DEPTH),
		.item_t(response_t)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_item(back_res),
		.pop    (pop),
		.rd_item(response),
		.status (res_status)
	);

endmodule

FILE: rtl/core/eft_checker.sv
// Port-level checker for the event flag table core, bound to the top level.
// Depends on eft_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eft_checker
	import eft_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input request_t  request,
	input logic      empty,
	input logic      pop,
	input response_t response
);

	// A waiting response holds until it is taken.
	`EFT_ASSERT_MSG(a_resp_hold, !empty && !pop |=> !empty && $stable(response), "response changed while stalled")

	// A failed command never reports an allocated source.
	`EFT_ASSERT(a_fail_no_source, !empty && !response.success |-> response.new_source == 8'd0)

	// The request side fills up only through an accepted item.
	`EFT_ASSERT_MSG(a_full_by_push, $rose(full) |-> $past(push), "full rose without a push")

endmodule

bind event_flag_table_core eft_checker u_eft_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.push    (push),
	.full    (full),
	.request (request),
	.empty   (empty),
	.pop     (pop),
	.response(response)
);
